// File: rtl/sef_pkg.sv
// shared types, constants and fixed-point helpers for the sir euler fit error block
package sef_pkg;

    localparam int SUBSTEPS_DEF = 10;
    localparam int FRAC_BITS    = 30;
    localparam int IDX_W        = 8;
    localparam int DATA_W       = 32;

    localparam logic [IDX_W-1:0] REG_FIXED_MODE    = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_INIT_SUSCEPT  = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_BETA          = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_GAMMA         = IDX_W'(3);

    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [30:0] INIT_S_RST  = 31'h4000_0000;
    localparam logic [31:0] POS_MAX     = 32'h7fff_ffff;
    localparam logic [31:0] NEG_MIN     = 32'h8000_0000;

    typedef struct packed {
        logic        fixed_mode;
        logic [30:0] initial_susceptible;
        logic [30:0] beta;
        logic [30:0] gamma;
    } cfg_t;

    typedef struct packed {
        logic [30:0] observed;
        logic        skip;
        logic        first;
        logic        last;
    } item_t;

    typedef struct packed {
        logic signed [31:0] infected;
        logic [47:0]        error;
        logic               series_end;
    } res_t;

    typedef struct packed {
        logic signed [32:0] a;
        logic signed [32:0] b;
    } mul_op_t;

    // floor shift by 30 then clamp to signed 32 bits
    function automatic logic signed [31:0] q30_sat(input logic signed [65:0] p);
        logic signed [31:0] r;
        if ((p[65:61] == 5'b00000) || (p[65:61] == 5'b11111))
        begin
            r = p[61:30];
        end
        else
        begin
            r = p[65] ? NEG_MIN : POS_MAX;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if ((v[33:31] == 3'b000) || (v[33:31] == 3'b111))
        begin
            r = v[31:0];
        end
        else
        begin
            r = v[33] ? NEG_MIN : POS_MAX;
        end
        return r;
    endfunction

endpackage

// File: rtl/sef_mul.sv
// shared signed multiplier with registered product
module sef_mul (
    input  logic                clk,
    input  sef_pkg::mul_op_t    op,
    output logic signed [65:0]  prod
);
    import sef_pkg::*;

    logic signed [65:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 66'(op.a) * 66'(op.b);
    end

    assign prod = prod_reg;

endmodule

// File: rtl/sef_core.sv
// sequencer and datapath for the euler substeps and the error update
module sef_core #(
    parameter int SUBSTEPS = sef_pkg::SUBSTEPS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  sef_pkg::cfg_t   cfg,
    input  logic            start,
    input  sef_pkg::item_t  item,
    input  logic            take,
    output logic            idle,
    output logic            done,
    output sef_pkg::res_t   res
);
    import sef_pkg::*;

    localparam int CNT_W = $clog2(SUBSTEPS + 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MUL_SI = 9'b000000010,
        S_MUL_IG = 9'b000000100,
        S_MUL_SB = 9'b000001000,
        S_UPDATE = 9'b000010000,
        S_DIFF   = 9'b000100000,
        S_SQUARE = 9'b001000000,
        S_ACC    = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [31:0] s_reg, s_next;
    logic signed [31:0] i_reg, i_next;
    logic [47:0]        acc_reg, acc_next;
    logic signed [31:0] p_reg, p_next;
    logic signed [31:0] ig_reg, ig_next;
    logic [31:0]        mag_reg, mag_next;
    logic [30:0]        obs_reg, obs_next;
    logic               skip_reg, skip_next;
    logic               last_reg, last_next;

    mul_op_t            op;
    logic signed [65:0] prod;
    logic signed [31:0] prod_q;
    logic signed [32:0] diff;
    logic [48:0]        sum;

    sef_mul u_mul (
        .clk  (clk),
        .op   (op),
        .prod (prod)
    );

    assign prod_q = q30_sat(prod);
    assign diff   = signed'({2'b00, obs_reg}) - signed'({i_reg[31], i_reg});
    assign sum    = {1'b0, acc_reg} + {15'd0, prod[63:30]};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_next     = s_reg;
        i_next     = i_reg;
        acc_next   = acc_reg;
        p_next     = p_reg;
        ig_next    = ig_reg;
        mag_next   = mag_reg;
        obs_next   = obs_reg;
        skip_next  = skip_reg;
        last_next  = last_reg;
        op         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    obs_next  = item.observed;
                    skip_next = item.skip;
                    last_next = item.last;
                    cnt_next  = '0;
                    if (item.first)
                    begin
                        i_next     = signed'({1'b0, item.observed});
                        s_next     = cfg.fixed_mode
                                   ? signed'({1'b0, ONE_Q30} - {1'b0, item.observed})
                                   : signed'({1'b0, cfg.initial_susceptible});
                        acc_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MUL_SI;
                    end
                end
            end
            S_MUL_SI:
            begin
                op.a       = {s_reg[31], s_reg};
                op.b       = {i_reg[31], i_reg};
                state_next = S_MUL_IG;
            end
            S_MUL_IG:
            begin
                p_next     = prod_q;
                op.a       = {i_reg[31], i_reg};
                op.b       = signed'({2'b00, cfg.gamma});
                state_next = S_MUL_SB;
            end
            S_MUL_SB:
            begin
                ig_next    = prod_q;
                op.a       = {p_reg[31], p_reg};
                op.b       = signed'({2'b00, cfg.beta});
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                s_next = sat34(signed'({{2{s_reg[31]}}, s_reg})
                             - signed'({{2{prod_q[31]}}, prod_q}));
                i_next = sat34(signed'({{2{i_reg[31]}}, i_reg})
                             + signed'({{2{prod_q[31]}}, prod_q})
                             - signed'({{2{ig_reg[31]}}, ig_reg}));
                if (cnt_reg == CNT_W'(SUBSTEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = skip_reg ? S_DONE : S_DIFF;
                end
                else
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_MUL_SI;
                end
            end
            S_DIFF:
            begin
                mag_next   = diff[32] ? 32'(-diff) : diff[31:0];
                state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                op.a       = signed'({1'b0, mag_reg});
                op.b       = signed'({1'b0, mag_reg});
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next   = sum[48] ? '1 : sum[47:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            s_reg     <= '0;
            i_reg     <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            s_reg     <= s_next;
            i_reg     <= i_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        ig_reg   <= ig_next;
        mag_reg  <= mag_next;
        obs_reg  <= obs_next;
        skip_reg <= skip_next;
        last_reg <= last_next;
    end

    assign idle           = (state_reg == S_IDLE);
    assign done           = (state_reg == S_DONE);
    assign res.infected   = i_reg;
    assign res.error      = acc_reg;
    assign res.series_end = last_reg;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(SUBSTEPS - 1))
        else $error("substep count out of range");

    a_acc_grows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACC |=> acc_reg >= $past(acc_reg))
        else $error("error sum fell on accumulate");
`endif

endmodule

// File: rtl/sir_euler_fit_error.sv
// top level of the sir euler fit error block: config registers, core and output register
//
// channel | direction | handshake              | carries
// in      | sink      | in_valid / in_ready    | observed, skip, first, last
// out     | source    | out_valid / out_ready  | simulated_infected, error_sum, series_end
// cfg     | sink      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// a first word only loads the model state; any other runs SUBSTEPS euler substeps
// and, unless skip is set, the error update, all through the one shared multiplier
// each substep issues three products in turn, then one squaring per word without skip
// in_ready is high only while the core is idle; cfg_ready is always high
// a finished word waits in the core while the output register is held by out_ready
// rst_n clears control and model state and resets the config registers
module sir_euler_fit_error #(
    parameter int SUBSTEPS = sef_pkg::SUBSTEPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [30:0]                 observed,
    input  logic                        skip,
    input  logic                        first,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [31:0]          simulated_infected,
    output logic [47:0]                 error_sum,
    output logic                        series_end,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sef_pkg::IDX_W-1:0]   cfg_index,
    input  logic [sef_pkg::DATA_W-1:0]  cfg_data
);
    import sef_pkg::*;

    cfg_t   cfg_reg;
    item_t  item;
    res_t   core_res;
    res_t   res_reg;
    logic   out_valid_reg;
    logic   core_idle;
    logic   core_done;
    logic   load;

    assign cfg_ready = 1'b1;
    assign in_ready  = core_idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fixed_mode          <= 1'b0;
            cfg_reg.initial_susceptible <= INIT_S_RST;
            cfg_reg.beta                <= '0;
            cfg_reg.gamma               <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FIXED_MODE:   cfg_reg.fixed_mode          <= cfg_data[0];
                REG_INIT_SUSCEPT: cfg_reg.initial_susceptible <= cfg_data[30:0];
                REG_BETA:         cfg_reg.beta                <= cfg_data[30:0];
                REG_GAMMA:        cfg_reg.gamma               <= cfg_data[30:0];
                default:          cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    assign item.observed = observed;
    assign item.skip     = skip;
    assign item.first    = first;
    assign item.last     = last;

    sef_core #(
        .SUBSTEPS (SUBSTEPS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .start (in_valid),
        .item  (item),
        .take  (load),
        .idle  (core_idle),
        .done  (core_done),
        .res   (core_res)
    );

    assign load = core_done && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= core_res;
        end
    end

    assign out_valid          = out_valid_reg;
    assign simulated_infected = res_reg.infected;
    assign error_sum          = res_reg.error;
    assign series_end         = res_reg.series_end;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("core took a second word while busy");

    a_out_from_core: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(core_done))
        else $error("output word without a finished core word");
`endif

endmodule
